// ===== hdl/lodts_pkg.sv =====
// Shared constants, tables and types for the LOD dither threshold select unit.
`timescale 1ns / 1ps

package lodts_pkg;

	// Coordinate bits of pixel_x and pixel_y that take part in the pattern.
	localparam int COORD_BITS = 16;
	localparam int PIX_W      = 16;
	localparam logic [PIX_W-1:0] COORD_MASK = PIX_W'((33'd1 << COORD_BITS) - 33'd1);

	localparam int BLEND_W    = 17;
	localparam int THR_W      = 16;
	localparam int MODE_W     = 2;
	localparam int STRENGTH_W = 9;
	localparam int FRAME_W    = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRENGTH      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_JITTER_ENABLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_NUMBER  = 2'd3;

	// Pattern modes.
	localparam logic [MODE_W-1:0] MODE_BAYER4   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BAYER8   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_NOISE    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TEMPORAL = 2'd3;

	localparam logic [MODE_W-1:0]     RESET_MODE     = MODE_BAYER8;
	localparam logic [STRENGTH_W-1:0] STRENGTH_ONE   = 9'd256;
	localparam logic [STRENGTH_W-1:0] RESET_STRENGTH = STRENGTH_ONE;

	// Noise coordinate offsets per frame; frame*47 plus a coordinate fits 22 bits.
	localparam int OFF_W = 22;
	localparam int ODD_W = OFF_W + 1;
	localparam logic [OFF_W-1:0] FRAME_X_STEP = 22'd47;
	localparam logic [OFF_W-1:0] FRAME_Y_STEP = 22'd31;

	// Gradient noise coefficients: inner terms in Q0.32, outer scale 52 + frac.
	localparam int INNER_W = 33;
	localparam int FRAC_W  = 32;
	localparam logic [INNER_W-1:0] NOISE_A_Q32      = 33'd288237660;
	localparam logic [INNER_W-1:0] NOISE_B_Q32      = 33'd25070368;
	localparam logic [FRAC_W-1:0]  NOISE_C_INT      = 32'd52;
	localparam logic [FRAC_W-1:0]  NOISE_C_FRAC_Q32 = 32'd4221604530;

	localparam int SUM_W = 25;
	localparam logic [THR_W-1:0] HALF_Q16 = 16'd32768;

	localparam logic [3:0] BAYER4 [16] = '{
		4'd0,  4'd8,  4'd2,  4'd10,
		4'd12, 4'd4,  4'd14, 4'd6,
		4'd3,  4'd11, 4'd1,  4'd9,
		4'd15, 4'd7,  4'd13, 4'd5
	};

	localparam logic [5:0] BAYER8 [64] = '{
		6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
		6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
		6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
		6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
		6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
		6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
		6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
		6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
	};

	typedef struct packed {
		logic [MODE_W-1:0]     mode;
		logic [STRENGTH_W-1:0] strength;   // already limited to 256
		logic                  jitter;
		logic [OFF_W-1:0]      off_x;      // frame * 47
		logic [OFF_W-1:0]      off_y;      // frame * 31
	} cfg_t;

	// Load enables of the noise pipeline stages.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} noise_en_t;

endpackage

// ===== hdl/lod_dither_threshold_select_unit.sv =====
// Top level of the LOD dither threshold select unit: seven-stage pixel pipeline.
`timescale 1ns / 1ps
// Throughput: one pixel per cycle while the output is not stalled; each stage
// loads when it is empty or when the stage after it moves, so bubbles close
// up behind a stalled output.
// Reset clears all valid bits and returns the registers to Bayer 8x8 mode,
// full strength, jitter on and frame zero; it takes effect at once.
module lod_dither_threshold_select_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lodts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lodts_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [lodts_pkg::PIX_W-1:0]         pixel_x,
	input  logic [lodts_pkg::PIX_W-1:0]         pixel_y,
	input  logic [lodts_pkg::BLEND_W-1:0]       blend_fraction,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lodts_pkg::THR_W-1:0]         threshold_q16,
	output logic                                draw_first_level
);

	lodts_pkg::cfg_t      cfg;
	lodts_pkg::noise_en_t noise_en;

	// Stage valid bits and load enables. A stage loads when it holds nothing
	// or when its content moves on into the next stage in the same cycle.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	assign en_s7 = !v_s7 || !out_stall;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	lodts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 1: mask the coordinates, add the frame offsets and look up the
	// Bayer value that the mode asks for (4x4 in mode zero, 8x8 otherwise).
	logic [lodts_pkg::PIX_W-1:0]   x_m;
	logic [lodts_pkg::PIX_W-1:0]   y_m;
	logic [lodts_pkg::OFF_W-1:0]   ox;
	logic [lodts_pkg::OFF_W-1:0]   oy;
	logic [lodts_pkg::THR_W-1:0]   bayer4_v;
	logic [lodts_pkg::THR_W-1:0]   bayer8_v;
	logic [lodts_pkg::ODD_W-1:0]   odd_x_s1;
	logic [lodts_pkg::ODD_W-1:0]   odd_y_s1;
	logic [lodts_pkg::THR_W-1:0]   bay_s1, bay_s2, bay_s3, bay_s4;
	logic [lodts_pkg::BLEND_W-1:0] blend_s1, blend_s2, blend_s3, blend_s4;
	logic [lodts_pkg::BLEND_W-1:0] blend_s5, blend_s6;

	assign x_m      = pixel_x & lodts_pkg::COORD_MASK;
	assign y_m      = pixel_y & lodts_pkg::COORD_MASK;
	assign ox       = lodts_pkg::OFF_W'(x_m) + cfg.off_x;
	assign oy       = lodts_pkg::OFF_W'(y_m) + cfg.off_y;
	assign bayer4_v = {lodts_pkg::BAYER4[{y_m[1:0], x_m[1:0]}], 12'd0};
	assign bayer8_v = {lodts_pkg::BAYER8[{y_m[2:0], x_m[2:0]}], 10'd0};

	always_ff @(posedge clk) begin
		if (en_s1) begin
			odd_x_s1 <= {ox, 1'b1};
			odd_y_s1 <= {oy, 1'b1};
			bay_s1   <= (cfg.mode == lodts_pkg::MODE_BAYER4) ? bayer4_v : bayer8_v;
			blend_s1 <= blend_fraction;
		end
	end

	// Stages 2 to 4: the noise pipeline; the Bayer value and blend ride along.
	logic [lodts_pkg::THR_W-1:0] noise;

	assign noise_en.s2 = en_s2;
	assign noise_en.s3 = en_s3;
	assign noise_en.s4 = en_s4;

	lodts_noise u_noise (
		.clk      (clk),
		.en       (noise_en),
		.odd_x_s1 (odd_x_s1),
		.odd_y_s1 (odd_y_s1),
		.noise    (noise)
	);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			bay_s2   <= bay_s1;
			blend_s2 <= blend_s1;
		end
		if (en_s3) begin
			bay_s3   <= bay_s2;
			blend_s3 <= blend_s2;
		end
		if (en_s4) begin
			bay_s4   <= bay_s3;
			blend_s4 <= blend_s3;
		end
	end

	// Stage 5: pick the raw threshold. Temporal mode adds a quarter of the
	// noise to the 8x8 value and wraps modulo one when jitter is on.
	logic [lodts_pkg::THR_W-1:0] t_sel;
	logic [lodts_pkg::THR_W-1:0] t_s5;

	always_comb begin
		case (cfg.mode)
			lodts_pkg::MODE_NOISE: begin
				t_sel = noise;
			end
			lodts_pkg::MODE_TEMPORAL: begin
				t_sel = cfg.jitter ? bay_s4 + {2'b00, noise[lodts_pkg::THR_W-1:2]} : bay_s4;
			end
			default: begin
				t_sel = bay_s4;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			t_s5     <= t_sel;
			blend_s5 <= blend_s4;
		end
	end

	// Stage 6: pull the threshold toward one half by the strength factor.
	// The weighted sum stays below 2^24, so bits 23:8 are the full result.
	logic [lodts_pkg::SUM_W-1:0] half_term;
	logic [lodts_pkg::SUM_W-1:0] pat_term;
	logic [lodts_pkg::SUM_W-1:0] mix_sum;
	logic [lodts_pkg::THR_W-1:0] thr_s6;

	assign half_term = lodts_pkg::SUM_W'(lodts_pkg::HALF_Q16) *
	                   lodts_pkg::SUM_W'(lodts_pkg::STRENGTH_ONE - cfg.strength);
	assign pat_term  = lodts_pkg::SUM_W'(t_s5) * lodts_pkg::SUM_W'(cfg.strength);
	assign mix_sum   = half_term + pat_term;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			thr_s6   <= mix_sum[8 +: lodts_pkg::THR_W];
			blend_s6 <= blend_s5;
		end
	end

	// Stage 7: output register with the level decision.
	logic [lodts_pkg::THR_W-1:0] thr_s7;
	logic                        draw_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			thr_s7  <= thr_s6;
			draw_s7 <= blend_s6 < lodts_pkg::BLEND_W'(thr_s6);
		end
	end

	assign out_valid        = v_s7;
	assign threshold_q16    = thr_s7;
	assign draw_first_level = draw_s7;

endmodule

// ===== hdl/lodts_cfg.sv =====
// Configuration registers with precomputed per-frame noise offsets.
`timescale 1ns / 1ps

module lodts_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [lodts_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lodts_pkg::CFG_DATA_W-1:0]      cfg_data,
	output lodts_pkg::cfg_t                       cfg
);

	logic [lodts_pkg::MODE_W-1:0]     mode_q;
	logic [lodts_pkg::STRENGTH_W-1:0] strength_q;
	logic                             jitter_q;
	logic [lodts_pkg::OFF_W-1:0]      off_x_q;
	logic [lodts_pkg::OFF_W-1:0]      off_y_q;
	logic [lodts_pkg::FRAME_W-1:0]    frame_w;

	assign frame_w = cfg_data[lodts_pkg::FRAME_W-1:0];

	// The frame offsets are formed when the frame number is written, so the
	// pixel path only adds them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= lodts_pkg::RESET_MODE;
			strength_q <= lodts_pkg::RESET_STRENGTH;
			jitter_q   <= 1'b1;
			off_x_q    <= '0;
			off_y_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lodts_pkg::REG_PATTERN_MODE: begin
					mode_q <= cfg_data[lodts_pkg::MODE_W-1:0];
				end
				lodts_pkg::REG_STRENGTH: begin
					strength_q <= cfg_data[lodts_pkg::STRENGTH_W-1:0];
				end
				lodts_pkg::REG_JITTER_ENABLE: begin
					jitter_q <= cfg_data[0];
				end
				lodts_pkg::REG_FRAME_NUMBER: begin
					off_x_q <= lodts_pkg::OFF_W'(frame_w) * lodts_pkg::FRAME_X_STEP;
					off_y_q <= lodts_pkg::OFF_W'(frame_w) * lodts_pkg::FRAME_Y_STEP;
				end
			endcase
		end
	end

	always_comb begin
		cfg.mode     = mode_q;
		cfg.strength = (strength_q > lodts_pkg::STRENGTH_ONE) ? lodts_pkg::STRENGTH_ONE
		                                                       : strength_q;
		cfg.jitter   = jitter_q;
		cfg.off_x    = off_x_q;
		cfg.off_y    = off_y_q;
	end

endmodule

// ===== hdl/lodts_noise.sv =====
// Three-stage interleaved gradient noise pipeline.
`timescale 1ns / 1ps

module lodts_noise (
	input  logic                              clk,
	input  lodts_pkg::noise_en_t              en,
	input  logic [lodts_pkg::ODD_W-1:0]       odd_x_s1,
	input  logic [lodts_pkg::ODD_W-1:0]       odd_y_s1,
	output logic [lodts_pkg::THR_W-1:0]       noise
);

	logic [lodts_pkg::INNER_W-1:0] pa_s2;
	logic [lodts_pkg::INNER_W-1:0] pb_s2;
	logic [lodts_pkg::INNER_W-1:0] inner;
	logic [lodts_pkg::FRAC_W-1:0]  f_s3;
	logic [lodts_pkg::FRAC_W-1:0]  p52_s4;
	logic [lodts_pkg::FRAC_W-1:0]  phi_s4;
	logic [2*lodts_pkg::FRAC_W-1:0] frac_prod;
	logic [lodts_pkg::FRAC_W-1:0]  outer;

	assign inner     = pa_s2 + pb_s2;
	assign frac_prod = (2*lodts_pkg::FRAC_W)'(lodts_pkg::NOISE_C_FRAC_Q32) *
	                   (2*lodts_pkg::FRAC_W)'(f_s3);
	assign outer     = p52_s4 + phi_s4;
	assign noise     = outer[lodts_pkg::FRAC_W-1 -: lodts_pkg::THR_W];

	// Only the low 33 bits of each inner product matter, as the sum wraps.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			pa_s2 <= lodts_pkg::NOISE_A_Q32 * lodts_pkg::INNER_W'(odd_x_s1);
			pb_s2 <= lodts_pkg::NOISE_B_Q32 * lodts_pkg::INNER_W'(odd_y_s1);
		end
		if (en.s3) begin
			f_s3 <= inner[lodts_pkg::INNER_W-1:1];
		end
		if (en.s4) begin
			p52_s4 <= f_s3 * lodts_pkg::NOISE_C_INT;
			phi_s4 <= frac_prod[2*lodts_pkg::FRAC_W-1 -: lodts_pkg::FRAC_W];
		end
	end

endmodule

// ===== hdl/lodts_checker.sv =====
// Port-level checker for the LOD dither threshold select unit, with its bind.
`timescale 1ns / 1ps

module lodts_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [lodts_pkg::THR_W-1:0]        threshold_q16,
	input logic                               draw_first_level
);

	// Input backpressure arises only from a result that waits at the output.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while no output beat waits");

	// The first level can only be drawn under a nonzero threshold.
	a_draw_thr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && draw_first_level) |-> (threshold_q16 != '0))
		else $error("draw_first_level set with zero threshold");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(threshold_q16) && $stable(draw_first_level)))
		else $error("stalled output beat changed");

endmodule

bind lod_dither_threshold_select_unit lodts_checker u_lodts_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.threshold_q16    (threshold_q16),
	.draw_first_level (draw_first_level)
);

// ===== test/tb_lod_dither_threshold_select_unit.sv =====
// Self-checking testbench for the LOD dither threshold select unit, with directed and random beats.
`timescale 1ns / 1ps

// The bench drives pixel beats through the valid/stall input channel.
// It predicts each threshold with its own model of the Bayer and gradient
// noise patterns and the strength blend, and checks every output beat in order.
// A directed table comes first. It covers reset state, the Bayer extremes,
// strength saturation, register masking and the blend limits. Random
// phases follow, with different sender idle and receiver stall rates.
module tb_lod_dither_threshold_select_unit;

	localparam int QUIET_LIMIT  = 2000;   // cycles without any accepted beat
	localparam int NUM_DIRECTED = 23;
	localparam int BEATS_PER_SETTING = 50;
	localparam int MAX_REPORTS  = 10;

	// Gradient noise coefficients in Q0.32, plus the integer part of the outer scale.
	localparam logic [63:0] IGN_A      = 64'd288237660;
	localparam logic [63:0] IGN_B      = 64'd25070368;
	localparam logic [63:0] IGN_C_INT  = 64'd52;
	localparam logic [63:0] IGN_C_FRAC = 64'd4221604530;

	localparam int BAYER4_RANK [16] = '{
		0, 8, 2, 10,
		12, 4, 14, 6,
		3, 11, 1, 9,
		15, 7, 13, 5
	};

	localparam int BAYER8_RANK [64] = '{
		0, 32, 8, 40, 2, 34, 10, 42,
		48, 16, 56, 24, 50, 18, 58, 26,
		12, 44, 4, 36, 14, 46, 6, 38,
		60, 28, 52, 20, 62, 30, 54, 22,
		3, 35, 11, 43, 1, 33, 9, 41,
		51, 19, 59, 27, 49, 17, 57, 25,
		15, 47, 7, 39, 13, 45, 5, 37,
		63, 31, 55, 23, 61, 29, 53, 21
	};

	localparam logic [lodts_pkg::MODE_W-1:0] MODE_ORDER [4] = '{
		lodts_pkg::MODE_BAYER4, lodts_pkg::MODE_BAYER8,
		lodts_pkg::MODE_NOISE, lodts_pkg::MODE_TEMPORAL
	};

	typedef struct packed {
		logic [lodts_pkg::THR_W-1:0] thr;
		logic                        draw;
	} thr_beat_t;

	// One directed row: the register setting it needs, the pixel beat, and
	// optionally a threshold that is written out by hand.
	typedef struct packed {
		logic [lodts_pkg::MODE_W-1:0]     mode;
		logic [lodts_pkg::CFG_DATA_W-1:0] strength;   // raw register data, masked by the block
		logic                             jitter;
		logic [lodts_pkg::FRAME_W-1:0]    frame;
		logic [lodts_pkg::PIX_W-1:0]      x;
		logic [lodts_pkg::PIX_W-1:0]      y;
		logic [lodts_pkg::BLEND_W-1:0]    blend;
		logic                             typed;
		logic [lodts_pkg::THR_W-1:0]      thr;
		logic                             draw;
	} pixel_row_t;

	// Rows with typed = 0 are checked against the predictor.
	localparam pixel_row_t PIXEL_TABLE [NUM_DIRECTED] = '{
		// Reset setting: Bayer 8x8 at full strength, corner entries.
		'{lodts_pkg::MODE_BAYER8, 16'd256, 1'b1, 16'd0, 16'd0, 16'd0, 17'd0,
			1'b1, 16'd0, 1'b0},
		'{lodts_pkg::MODE_BAYER8, 16'd256, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF, 17'd0,
			1'b1, 16'd21504, 1'b1},
		'{lodts_pkg::MODE_BAYER8, 16'd256, 1'b1, 16'd0, 16'd0, 16'd7, 17'd64511,
			1'b1, 16'd64512, 1'b1},
		// A full blend and a blend beyond one never draw the first level.
		'{lodts_pkg::MODE_BAYER8, 16'd256, 1'b1, 16'd0, 16'd0, 16'd7, 17'd65536,
			1'b1, 16'd64512, 1'b0},
		'{lodts_pkg::MODE_BAYER8, 16'd256, 1'b1, 16'd0, 16'd0, 16'd7, 17'h1FFFF,
			1'b1, 16'd64512, 1'b0},
		// Bayer 4x4, including a blend equal to the threshold.
		'{lodts_pkg::MODE_BAYER4, 16'd256, 1'b1, 16'd0, 16'd3, 16'd3, 17'd20479,
			1'b1, 16'd20480, 1'b1},
		'{lodts_pkg::MODE_BAYER4, 16'd256, 1'b1, 16'd0, 16'd0, 16'd3, 17'd61440,
			1'b1, 16'd61440, 1'b0},
		'{lodts_pkg::MODE_BAYER4, 16'd256, 1'b1, 16'd0, 16'hFFFC, 16'd3, 17'd0,
			1'b1, 16'd61440, 1'b1},
		// Zero strength pins the threshold at one half.
		'{lodts_pkg::MODE_BAYER4, 16'd0, 1'b1, 16'd0, 16'd0, 16'd3, 17'd32767,
			1'b1, 16'd32768, 1'b1},
		'{lodts_pkg::MODE_BAYER4, 16'd0, 1'b1, 16'd0, 16'd0, 16'd3, 17'd32768,
			1'b1, 16'd32768, 1'b0},
		// Strength above one saturates; upper data bits beyond nine are dropped.
		'{lodts_pkg::MODE_BAYER4, 16'hFFFF, 1'b1, 16'd0, 16'd0, 16'd3, 17'd0,
			1'b1, 16'd61440, 1'b1},
		'{lodts_pkg::MODE_BAYER8, 16'd128, 1'b1, 16'd0, 16'd0, 16'd0, 17'd16383,
			1'b1, 16'd16384, 1'b1},
		'{lodts_pkg::MODE_BAYER8, 16'hFF00, 1'b1, 16'd0, 16'd1, 16'd0, 17'd0,
			1'b1, 16'd32768, 1'b1},
		// Gradient noise at frame extremes.
		'{lodts_pkg::MODE_NOISE, 16'd256, 1'b1, 16'd0, 16'd0, 16'd0, 17'd0,
			1'b0, 16'd0, 1'b0},
		'{lodts_pkg::MODE_NOISE, 16'd256, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'd0,
			1'b0, 16'd0, 1'b0},
		'{lodts_pkg::MODE_NOISE, 16'd256, 1'b1, 16'hFFFF, 16'd0, 16'd0, 17'd32768,
			1'b0, 16'd0, 1'b0},
		'{lodts_pkg::MODE_NOISE, 16'd256, 1'b1, 16'd12345, 16'h5A5A, 16'hA5A5, 17'd40000,
			1'b0, 16'd0, 1'b0},
		// Temporal mode with jitter off is plain Bayer 8x8.
		'{lodts_pkg::MODE_TEMPORAL, 16'd256, 1'b0, 16'd12345, 16'd1, 16'd0, 17'd32768,
			1'b1, 16'd32768, 1'b0},
		'{lodts_pkg::MODE_TEMPORAL, 16'd256, 1'b0, 16'd12345, 16'd7, 16'd7, 17'd21503,
			1'b1, 16'd21504, 1'b1},
		'{lodts_pkg::MODE_TEMPORAL, 16'd256, 1'b1, 16'd12345, 16'd1, 16'd0, 17'd0,
			1'b0, 16'd0, 1'b0},
		'{lodts_pkg::MODE_TEMPORAL, 16'd256, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'd65535,
			1'b0, 16'd0, 1'b0},
		'{lodts_pkg::MODE_TEMPORAL, 16'd64, 1'b1, 16'd0, 16'd3, 16'd5, 17'd30000,
			1'b0, 16'd0, 1'b0},
		'{lodts_pkg::MODE_NOISE, 16'd200, 1'b1, 16'd1, 16'd100, 16'd200, 17'd65536,
			1'b0, 16'd0, 1'b0}
	};

	logic                             clk;
	logic                             arst_n           = 1'b0;
	logic                             cfg_we           = 1'b0;
	logic [lodts_pkg::CFG_IDX_W-1:0]  cfg_index        = lodts_pkg::REG_PATTERN_MODE;
	logic [lodts_pkg::CFG_DATA_W-1:0] cfg_data         = '0;
	logic                             in_valid         = 1'b0;
	logic                             in_stall;
	logic [lodts_pkg::PIX_W-1:0]      pixel_x          = '0;
	logic [lodts_pkg::PIX_W-1:0]      pixel_y          = '0;
	logic [lodts_pkg::BLEND_W-1:0]    blend_fraction   = '0;
	logic                             out_valid;
	logic                             out_stall        = 1'b0;
	logic [lodts_pkg::THR_W-1:0]      threshold_q16;
	logic                             draw_first_level;

	// Hand-typed expectation that travels with the pixel beat.
	logic                             beat_typed       = 1'b0;
	logic [lodts_pkg::THR_W-1:0]      beat_thr         = '0;
	logic                             beat_draw        = 1'b0;

	// The register values the block should hold, as the block masks them.
	logic [lodts_pkg::MODE_W-1:0]     reg_mode         = lodts_pkg::RESET_MODE;
	logic [lodts_pkg::STRENGTH_W-1:0] reg_strength     = lodts_pkg::RESET_STRENGTH;
	logic                             reg_jitter       = 1'b1;
	logic [lodts_pkg::FRAME_W-1:0]    reg_frame        = '0;

	thr_beat_t pending_thresholds [$];
	int        mismatch_count   = 0;
	int        quiet_cycles     = 0;
	int        send_idle_pct    = 0;
	int        recv_stall_pct   = 0;

	lod_dither_threshold_select_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.pixel_x          (pixel_x),
		.pixel_y          (pixel_y),
		.blend_fraction   (blend_fraction),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.threshold_q16    (threshold_q16),
		.draw_first_level (draw_first_level)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Interleaved gradient noise in Q0.16. The offset coordinates are kept exactly.
	// The inner fraction wraps at 2^33, and the outer product wraps at one.
	function automatic logic [lodts_pkg::THR_W-1:0] gradient_noise(
			logic [lodts_pkg::PIX_W-1:0] x, logic [lodts_pkg::PIX_W-1:0] y);
		logic [63:0] ox, oy, inner, frac, outer;
		ox    = 64'(x) + 64'(reg_frame) * 64'd47;
		oy    = 64'(y) + 64'(reg_frame) * 64'd31;
		inner = IGN_A * (2 * ox + 1) + IGN_B * (2 * oy + 1);
		frac  = 64'(inner[32:1]);
		outer = IGN_C_INT * frac + ((IGN_C_FRAC * frac) >> 32);
		return outer[31:16];
	endfunction

	function automatic thr_beat_t predict_threshold(logic [lodts_pkg::PIX_W-1:0] x_in,
			logic [lodts_pkg::PIX_W-1:0] y_in, logic [lodts_pkg::BLEND_W-1:0] blend);
		logic [lodts_pkg::PIX_W-1:0] x, y;
		logic [lodts_pkg::THR_W-1:0] pattern, ordered8;
		int unsigned                 s, acc;
		thr_beat_t                   res;
		x        = x_in & lodts_pkg::COORD_MASK;
		y        = y_in & lodts_pkg::COORD_MASK;
		ordered8 = 16'(BAYER8_RANK[{y[2:0], x[2:0]}]) << 10;
		case (reg_mode)
			lodts_pkg::MODE_BAYER4: pattern = 16'(BAYER4_RANK[{y[1:0], x[1:0]}]) << 12;
			lodts_pkg::MODE_BAYER8: pattern = ordered8;
			lodts_pkg::MODE_NOISE:  pattern = gradient_noise(x, y);
			default: begin
				pattern = ordered8;
				if (reg_jitter)
					pattern = ordered8 + (gradient_noise(x, y) >> 2);
			end
		endcase
		// Pull toward one half; strength saturates at one.
		s        = (reg_strength > lodts_pkg::STRENGTH_ONE) ? 256 : reg_strength;
		acc      = 32768 * (256 - s) + pattern * s;
		res.thr  = 16'(acc >> 8);
		res.draw = (blend < {1'b0, res.thr});
		return res;
	endfunction

	// Receiver side: random stall at the rate of the current phase.
	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	// Both channels are sampled at the clock edge, before any of this edge's updates land.
	// The output beat is checked against the oldest expectation. An accepted
	// input beat adds its expectation to the queue.
	always @(posedge clk) begin : beat_monitor
		thr_beat_t want;
		bit        moved;
		if (arst_n) begin
			moved = 1'b0;
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				moved = 1'b1;
				if (pending_thresholds.size() == 0) begin
					if (mismatch_count < MAX_REPORTS)
						$display("%0t: unexpected output beat, threshold_q16 %0d draw %0b",
							$realtime, threshold_q16, draw_first_level);
					mismatch_count++;
				end else begin
					want = pending_thresholds.pop_front();
					if (threshold_q16 !== want.thr || draw_first_level !== want.draw) begin
						if (mismatch_count < MAX_REPORTS)
							$display("%0t: threshold_q16 exp %0d got %0d, draw exp %0b got %0b",
								$realtime, want.thr, threshold_q16, want.draw,
								draw_first_level);
						mismatch_count++;
					end
				end
			end
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				moved = 1'b1;
				if (beat_typed)
					pending_thresholds.push_back('{beat_thr, beat_draw});
				else
					pending_thresholds.push_back(
						predict_threshold(pixel_x, pixel_y, blend_fraction));
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
		end
	end

	// Watchdog: the run is stuck if no beat moves on either side for too long.
	initial begin
		wait (arst_n === 1'b1);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	// Offers one beat, after random idle cycles, and returns at the edge it is taken.
	task automatic send_pixel(logic [lodts_pkg::PIX_W-1:0] x, logic [lodts_pkg::PIX_W-1:0] y,
			logic [lodts_pkg::BLEND_W-1:0] blend, logic typed,
			logic [lodts_pkg::THR_W-1:0] thr, logic draw);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		pixel_x        <= x;
		pixel_y        <= y;
		blend_fraction <= blend;
		beat_typed     <= typed;
		beat_thr       <= thr;
		beat_draw      <= draw;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
	endtask

	// Stops the input and waits until every expected beat has come out.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_thresholds.size() != 0)
			@(posedge clk);
	endtask

	// Leaves the write enable high so writes can follow back to back; the caller lowers it.
	task automatic write_reg(logic [lodts_pkg::CFG_IDX_W-1:0] idx,
			logic [lodts_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			lodts_pkg::REG_PATTERN_MODE:  reg_mode     = data[lodts_pkg::MODE_W-1:0];
			lodts_pkg::REG_STRENGTH:      reg_strength = data[lodts_pkg::STRENGTH_W-1:0];
			lodts_pkg::REG_JITTER_ENABLE: reg_jitter   = data[0];
			lodts_pkg::REG_FRAME_NUMBER:  reg_frame    = data[lodts_pkg::FRAME_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [lodts_pkg::PIX_W-1:0] random_coord();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return lodts_pkg::PIX_W'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		pixel_row_t                       row;
		logic [lodts_pkg::MODE_W-1:0]     set_mode;
		logic [lodts_pkg::CFG_DATA_W-1:0] set_strength;
		logic                             set_jitter;
		logic [lodts_pkg::FRAME_W-1:0]    set_frame;
		logic [lodts_pkg::BLEND_W-1:0]    blend;
		bit                               changed;

		set_mode     = lodts_pkg::RESET_MODE;
		set_strength = lodts_pkg::CFG_DATA_W'(lodts_pkg::RESET_STRENGTH);
		set_jitter   = 1'b1;
		set_frame    = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, under light idling on both sides. The register setting
		// changes only between beats, once the pipeline is empty.
		send_idle_pct  = 21;
		recv_stall_pct = 21;
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			row     = PIXEL_TABLE[i];
			changed = (row.mode != set_mode) || (row.strength != set_strength) ||
				(row.jitter != set_jitter) || (row.frame != set_frame);
			if (changed) begin
				drain_pipeline();
				if (row.mode != set_mode)
					write_reg(lodts_pkg::REG_PATTERN_MODE,
						lodts_pkg::CFG_DATA_W'(row.mode));
				if (row.strength != set_strength)
					write_reg(lodts_pkg::REG_STRENGTH, row.strength);
				if (row.jitter != set_jitter)
					write_reg(lodts_pkg::REG_JITTER_ENABLE,
						lodts_pkg::CFG_DATA_W'(row.jitter));
				if (row.frame != set_frame)
					write_reg(lodts_pkg::REG_FRAME_NUMBER, row.frame);
				cfg_we       <= 1'b0;
				set_mode     = row.mode;
				set_strength = row.strength;
				set_jitter   = row.jitter;
				set_frame    = row.frame;
			end
			send_pixel(row.x, row.y, row.blend, row.typed, row.thr, row.draw);
		end

		// Random part: four idling phases, each with four register settings.
		// Mode and jitter writes carry random upper bits, which the block must drop.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			for (int round = 0; round < 4; round++) begin
				drain_pipeline();
				write_reg(lodts_pkg::REG_PATTERN_MODE,
					{14'($urandom), MODE_ORDER[(phase + round) % 4]});
				case ($urandom_range(0, 5))
					0:       write_reg(lodts_pkg::REG_STRENGTH, '0);
					1:       write_reg(lodts_pkg::REG_STRENGTH,
							lodts_pkg::CFG_DATA_W'(lodts_pkg::STRENGTH_ONE));
					2:       write_reg(lodts_pkg::REG_STRENGTH,
							lodts_pkg::CFG_DATA_W'($urandom_range(257, 65535)));
					default: write_reg(lodts_pkg::REG_STRENGTH,
							lodts_pkg::CFG_DATA_W'($urandom_range(0, 256)));
				endcase
				write_reg(lodts_pkg::REG_JITTER_ENABLE, {15'($urandom), 1'($urandom)});
				case ($urandom_range(0, 5))
					0:       write_reg(lodts_pkg::REG_FRAME_NUMBER, '0);
					1:       write_reg(lodts_pkg::REG_FRAME_NUMBER, '1);
					default: write_reg(lodts_pkg::REG_FRAME_NUMBER,
							lodts_pkg::CFG_DATA_W'($urandom));
				endcase
				cfg_we <= 1'b0;
				for (int n = 0; n < BEATS_PER_SETTING; n++) begin
					case ($urandom_range(0, 9))
						0:       blend = '0;
						1:       blend = 17'd65536;
						2:       blend = lodts_pkg::BLEND_W'($urandom_range(65537, 131071));
						default: blend = lodts_pkg::BLEND_W'($urandom_range(0, 65535));
					endcase
					send_pixel(random_coord(), random_coord(), blend, 1'b0, '0, 1'b0);
				end
			end
		end

		// Wait for the last beats, then keep watching for any stray output before the verdict.
		drain_pipeline();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
